// ===== sv/pose_region_box_displacement_assert.svh =====
// assertion helpers used by the select stage of the pose region box displacement block
`ifndef POSE_REGION_BOX_DISPLACEMENT_ASSERT_SVH
`define POSE_REGION_BOX_DISPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS
// property checked only while out of reset
`define PRBD_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("prbd assertion failed");
// property checked at every edge, reset included
`define PRBD_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("prbd assertion failed");
`else
`define PRBD_ASSERT(name, clk, rst_n, prop)
`define PRBD_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

// ===== sv/prbd_pkg.sv =====
package prbd_pkg;

    // number format
    localparam int FRAC_BITS  = 16;
    localparam int FIX_W      = 32;
    localparam int ANG_W      = FIX_W + 2;
    localparam int EXT_W      = FIX_W + 4;
    localparam int SQ_W       = 2 * FIX_W;
    localparam int CFG_W      = 2 * FIX_W;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_AXES   = 3;
    localparam int NUM_BOUNDS = 6;
    localparam int NUM_CAND   = 9;
    localparam int CAND_W     = 4;
    localparam int FIRST_FLIP = 5;

    // pi rounded to FRAC_BITS fraction bits, from a 60-bit fraction constant
    localparam logic [63:0] PI_2P60 = 64'h3243_F6A8_885A_308D;
    localparam logic [63:0] PI_WIDE =
        (PI_2P60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
    localparam logic signed [ANG_W-1:0] PI_Q = signed'(ANG_W'(PI_WIDE));

    // 1e-3 squared with 2*FRAC_BITS fraction bits, rounded
    localparam logic [CFG_W-1:0] THRESH_RESET =
        ((64'd1 << (2 * FRAC_BITS)) + 64'd500000) / 64'd1000000;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOUNDS_X,
        CFG_BOUNDS_Y,
        CFG_BOUNDS_Z,
        CFG_BOUNDS_ROLL,
        CFG_BOUNDS_PITCH,
        CFG_BOUNDS_YAW,
        CFG_NEAR_THRESH
    } cfg_idx_t;

    typedef logic signed [FIX_W-1:0] fix_t;
    typedef logic [SQ_W-1:0] sq_t;
    typedef fix_t [NUM_AXES-1:0] axes_t;
    typedef axes_t [NUM_CAND-1:0] cand_disp_t;
    typedef sq_t [NUM_AXES-1:0] sq3_t;
    typedef logic [NUM_BOUNDS-1:0][CFG_W-1:0] bounds_t;

    typedef struct packed {
        fix_t pos_x;
        fix_t pos_y;
        fix_t pos_z;
        fix_t angle_roll;
        fix_t angle_pitch;
        fix_t angle_yaw;
    } pose_t;

    typedef struct packed {
        fix_t              disp_x;
        fix_t              disp_y;
        fix_t              disp_z;
        fix_t              disp_roll;
        fix_t              disp_pitch;
        fix_t              disp_yaw;
        logic [CAND_W-1:0] chosen_offset;
        logic              in_constraint;
    } result_t;

    // one rotation candidate after measuring
    typedef struct packed {
        sq_t               sq;
        axes_t             d;
        logic [CAND_W-1:0] idx;
    } cand_t;

    typedef cand_t [NUM_CAND-1:0] cand_arr_t;

    // position part that rides along with the selection
    typedef struct packed {
        axes_t pos;
        sq_t   sq;
    } side_t;

    // saturate a wide signed value to the 32-bit range
    function automatic fix_t sat_fix(input logic signed [EXT_W-1:0] x);
        logic top_zero;
        logic top_one;
        top_zero = ~|x[EXT_W-1:FIX_W-1];
        top_one  = &x[EXT_W-1:FIX_W-1];
        if (top_zero || top_one)
            return x[FIX_W-1:0];
        else if (x[EXT_W-1])
            return {1'b1, {(FIX_W-1){1'b0}}};
        else
            return {1'b0, {(FIX_W-1){1'b1}}};
    endfunction

    // signed amount outside [min, max]; below min is tested first
    function automatic fix_t outside(input logic signed [ANG_W-1:0] v,
                                     input logic [CFG_W-1:0] b);
        logic signed [EXT_W-1:0] ve;
        logic signed [EXT_W-1:0] lo;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] diff;
        ve = EXT_W'(v);
        lo = EXT_W'($signed(b[FIX_W-1:0]));
        hi = EXT_W'($signed(b[CFG_W-1:FIX_W]));
        if (ve < lo)
            diff = ve - lo;
        else if (ve > hi)
            diff = ve - hi;
        else
            diff = '0;
        return sat_fix(diff);
    endfunction

    // square of a signed 32-bit value, exact in 64 bits
    function automatic sq_t square(input fix_t d);
        logic [FIX_W-1:0] m;
        m = d[FIX_W-1] ? (~d + 1'b1) : d;
        return SQ_W'(m) * SQ_W'(m);
    endfunction

    // keep the earlier candidate unless the later one is strictly smaller
    function automatic cand_t pick(input cand_t a, input cand_t b);
        return (b.sq < a.sq) ? b : a;
    endfunction

endpackage

// ===== sv/pose_region_box_displacement.sv =====
// a result strobes done after the input, displacement, square, sum, min tree and result registers
// throughput: one pose per cycle; busy stays low, the pipeline never holds an item
// the depth is set by the squaring stage and the four-level candidate min tree
// reset clears every stage valid, bounds to zero and the near threshold to 1e-3 squared
// results cannot be stalled: done is high for one cycle per item
module pose_region_box_displacement
    import prbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  pose_t                pose,
    output logic                 done,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic             in_v_reg;
    pose_t            pose_reg;
    bounds_t          bounds_reg;
    logic [CFG_W-1:0] thresh_reg;
    logic             done_reg;
    result_t          result_reg;
    result_t          result_next;
    logic             take;
    logic             disp_valid;
    axes_t            pos_disp;
    cand_disp_t       ang_disp;
    logic             norm_valid;
    cand_arr_t        cand;
    side_t            side;
    logic             best_valid;
    cand_t            best;
    side_t            best_side;
    logic [SQ_W:0]    total_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign take      = start && !busy;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounds_reg <= '0;
            thresh_reg <= THRESH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            for (int i = 0; i < NUM_BOUNDS; i++)
            begin
                if (cfg_index == CFG_IDX_W'(i))
                    bounds_reg[i] <= cfg_data;
            end
            if (cfg_index == CFG_NEAR_THRESH)
                thresh_reg <= cfg_data;
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_v_reg <= 1'b0;
        end
        else
        begin
            in_v_reg <= take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            pose_reg <= pose;
    end

    prbd_disp u_disp (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (in_v_reg),
        .pose       (pose_reg),
        .bounds     (bounds_reg),
        .disp_valid (disp_valid),
        .pos_disp   (pos_disp),
        .ang_disp   (ang_disp)
    );

    prbd_norm u_norm (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (disp_valid),
        .pos_disp   (pos_disp),
        .ang_disp   (ang_disp),
        .norm_valid (norm_valid),
        .cand       (cand),
        .side       (side)
    );

    prbd_select u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (norm_valid),
        .cand       (cand),
        .side       (side),
        .best_valid (best_valid),
        .best       (best),
        .best_side  (best_side)
    );

    // six-axis total; one extra bit stands in for saturation at all ones
    assign total_next = {1'b0, best_side.sq} + {1'b0, best.sq};

    always_comb
    begin
        result_next.disp_x        = best_side.pos[0];
        result_next.disp_y        = best_side.pos[1];
        result_next.disp_z        = best_side.pos[2];
        result_next.disp_roll     = best.d[0];
        result_next.disp_pitch    = best.d[1];
        result_next.disp_yaw      = best.d[2];
        result_next.chosen_offset = best.idx;
        result_next.in_constraint = (total_next < {1'b0, thresh_reg});
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= best_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== sv/prbd_disp.sv =====
module prbd_disp
    import prbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  pose_t      pose,
    input  bounds_t    bounds,
    output logic       disp_valid,
    output axes_t      pos_disp,
    output cand_disp_t ang_disp
);

    logic       v_reg;
    axes_t      pos_reg;
    cand_disp_t ang_reg;
    axes_t      pos_next;
    cand_disp_t ang_next;

    // position axes against their boxes
    assign pos_next[0] = outside(ANG_W'(pose.pos_x), bounds[CFG_BOUNDS_X]);
    assign pos_next[1] = outside(ANG_W'(pose.pos_y), bounds[CFG_BOUNDS_Y]);
    assign pos_next[2] = outside(ANG_W'(pose.pos_z), bounds[CFG_BOUNDS_Z]);

    // nine rotation candidates: roll sign slowest, yaw sign fastest
    for (genvar c = 0; c < NUM_CAND; c++) begin : g_cand
        localparam logic signed [ANG_W-1:0] OFF_ROLL =
            (c == 0) ? {ANG_W{1'b0}} : ((((c - 1) & 4) != 0) ? -PI_Q : PI_Q);
        localparam logic signed [ANG_W-1:0] OFF_PITCH =
            (c == 0) ? {ANG_W{1'b0}} : ((((c - 1) & 2) != 0) ? -PI_Q : PI_Q);
        localparam logic signed [ANG_W-1:0] OFF_YAW =
            (c == 0) ? {ANG_W{1'b0}} : ((((c - 1) & 1) != 0) ? -PI_Q : PI_Q);

        logic signed [ANG_W-1:0] a_roll;
        logic signed [ANG_W-1:0] a_pitch_sum;
        logic signed [ANG_W-1:0] a_pitch;
        logic signed [ANG_W-1:0] a_yaw;

        assign a_roll      = ANG_W'(pose.angle_roll) + OFF_ROLL;
        assign a_pitch_sum = ANG_W'(pose.angle_pitch) + OFF_PITCH;
        assign a_yaw       = ANG_W'(pose.angle_yaw) + OFF_YAW;
        // the later candidates mirror pitch
        assign a_pitch     = (c >= FIRST_FLIP) ? -a_pitch_sum : a_pitch_sum;

        assign ang_next[c][0] = outside(a_roll, bounds[CFG_BOUNDS_ROLL]);
        assign ang_next[c][1] = outside(a_pitch, bounds[CFG_BOUNDS_PITCH]);
        assign ang_next[c][2] = outside(a_yaw, bounds[CFG_BOUNDS_YAW]);
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= valid;
        end
    end

    // displacement registers
    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        ang_reg <= ang_next;
    end

    assign disp_valid = v_reg;
    assign pos_disp   = pos_reg;
    assign ang_disp   = ang_reg;

endmodule

// ===== sv/prbd_norm.sv =====
module prbd_norm
    import prbd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  axes_t      pos_disp,
    input  cand_disp_t ang_disp,
    output logic       norm_valid,
    output cand_arr_t  cand,
    output side_t      side
);

    logic                      sq_v_reg;
    logic                      sum_v_reg;
    axes_t                     pos_d_reg;
    cand_disp_t                ang_d_reg;
    sq3_t                      pos_sq_reg;
    sq3_t [NUM_CAND-1:0]       ang_sq_reg;
    sq3_t                      pos_sq_next;
    sq3_t [NUM_CAND-1:0]       ang_sq_next;
    cand_arr_t                 cand_reg;
    cand_arr_t                 cand_next;
    side_t                     side_reg;
    side_t                     side_next;

    // squares of every displacement
    always_comb
    begin
        for (int j = 0; j < NUM_AXES; j++)
        begin
            pos_sq_next[j] = square(pos_disp[j]);
        end
        for (int c = 0; c < NUM_CAND; c++)
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                ang_sq_next[c][j] = square(ang_disp[c][j]);
            end
        end
    end

    // three-term norms; each square is at most 2^62 so the sum fits
    always_comb
    begin
        for (int c = 0; c < NUM_CAND; c++)
        begin
            cand_next[c].sq  = ang_sq_reg[c][0] + ang_sq_reg[c][1] + ang_sq_reg[c][2];
            cand_next[c].d   = ang_d_reg[c];
            cand_next[c].idx = CAND_W'(c);
        end
        side_next.pos = pos_d_reg;
        side_next.sq  = pos_sq_reg[0] + pos_sq_reg[1] + pos_sq_reg[2];
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_v_reg  <= 1'b0;
            sum_v_reg <= 1'b0;
        end
        else
        begin
            sq_v_reg  <= valid;
            sum_v_reg <= sq_v_reg;
        end
    end

    // square and sum registers
    always_ff @(posedge clk)
    begin
        pos_d_reg  <= pos_disp;
        ang_d_reg  <= ang_disp;
        pos_sq_reg <= pos_sq_next;
        ang_sq_reg <= ang_sq_next;
        cand_reg   <= cand_next;
        side_reg   <= side_next;
    end

    assign norm_valid = sum_v_reg;
    assign cand       = cand_reg;
    assign side       = side_reg;

endmodule

// ===== sv/prbd_select.sv =====
`include "pose_region_box_displacement_assert.svh"

module prbd_select
    import prbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid,
    input  cand_arr_t cand,
    input  side_t     side,
    output logic      best_valid,
    output cand_t     best,
    output side_t     best_side
);

    logic [3:0]  v_reg;
    cand_t [4:0] l1_reg;
    cand_t [2:0] l2_reg;
    cand_t [1:0] l3_reg;
    cand_t       best_reg;
    side_t [3:0] side_reg;
    cand_t [4:0] l1_next;
    cand_t [2:0] l2_next;
    cand_t [1:0] l3_next;

    // min tree over nine candidates, left side always the earlier group
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            l1_next[i] = pick(cand[2*i], cand[2*i+1]);
        end
        l1_next[4] = cand[8];
        for (int i = 0; i < 2; i++)
        begin
            l2_next[i] = pick(l1_reg[2*i], l1_reg[2*i+1]);
        end
        l2_next[2] = l1_reg[4];
        l3_next[0] = pick(l2_reg[0], l2_reg[1]);
        l3_next[1] = l2_reg[2];
    end

    // level valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[2:0], valid};
        end
    end

    // tree levels, position part carried alongside
    always_ff @(posedge clk)
    begin
        l1_reg   <= l1_next;
        l2_reg   <= l2_next;
        l3_reg   <= l3_next;
        best_reg <= pick(l3_reg[0], l3_reg[1]);
        side_reg <= {side_reg[2:0], side};
    end

    assign best_valid = v_reg[3];
    assign best       = best_reg;
    assign best_side  = side_reg[3];

    // winner is never worse than the first or last candidate
    `PRBD_ASSERT(a_best_le_first, clk, rst_n, v_reg[3] |-> best_reg.sq <= $past(cand[0].sq, 4))
    `PRBD_ASSERT(a_best_le_last, clk, rst_n, v_reg[3] |-> best_reg.sq <= $past(cand[8].sq, 4))
    // winning index stays in the candidate range
    `PRBD_ASSERT(a_idx_range, clk, rst_n, v_reg[3] |-> best_reg.idx <= CAND_W'(NUM_CAND - 1))
    // reset empties the tree
    `PRBD_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> v_reg == '0)

endmodule

// ===== tb/displacement_checker.sv =====
module displacement_checker
    import prbd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 busy,
    input  pose_t                pose,
    input  logic                 done,
    input  result_t              result,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    output int                   errors,
    output int                   outstanding
);

    // half turn rounded to FRAC_BITS fraction bits
    localparam logic [63:0] PI_FRAC60 = 64'h3243_F6A8_885A_308D;
    localparam longint HALF_TURN =
        longint'((PI_FRAC60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
    localparam longint FIX_MAX = 64'sd2147483647;
    localparam longint FIX_MIN = -64'sd2147483648;

    logic [CFG_W-1:0] bounds_reg [NUM_BOUNDS];
    logic [CFG_W-1:0] near_limit;
    result_t          expected_results [$];
    int               fail_count;

    // clamp to the signed 32-bit range
    function automatic longint clip_fix(input longint v);
        if (v > FIX_MAX)
            return FIX_MAX;
        if (v < FIX_MIN)
            return FIX_MIN;
        return v;
    endfunction

    // signed distance outside [min, max], min tested first
    function automatic longint excess(input longint v, input logic [CFG_W-1:0] b);
        longint lo;
        longint hi;
        lo = longint'($signed(b[31:0]));
        hi = longint'($signed(b[63:32]));
        if (v < lo)
            return clip_fix(v - lo);
        if (v > hi)
            return clip_fix(v - hi);
        return 0;
    endfunction

    function automatic longint unsigned squared(input longint v);
        longint unsigned m;
        m = (v < 0) ? longint'(-v) : v;
        return m * m;
    endfunction

    // expected displacement of one pose under the current bounds
    function automatic result_t predict_displacement(input pose_t p);
        result_t         r;
        longint          ang [3];
        longint          trial [3];
        longint          d [3];
        longint          best [3];
        longint          pos_d [3];
        longint unsigned s;
        longint unsigned best_s;
        logic [64:0]     acc;
        int              best_idx;
        int unsigned     k;
        pos_d[0] = excess(p.pos_x, bounds_reg[CFG_BOUNDS_X]);
        pos_d[1] = excess(p.pos_y, bounds_reg[CFG_BOUNDS_Y]);
        pos_d[2] = excess(p.pos_z, bounds_reg[CFG_BOUNDS_Z]);
        ang[0] = p.angle_roll;
        ang[1] = p.angle_pitch;
        ang[2] = p.angle_yaw;
        best_s = 0;
        best_idx = 0;
        best = '{0, 0, 0};
        // try each half-turn offset, keep the smallest norm, earliest on ties
        for (int c = 0; c < NUM_CAND; c++)
        begin
            trial = ang;
            if (c > 0)
            begin
                k = c - 1;
                trial[0] += (k & 4) ? -HALF_TURN : HALF_TURN;
                trial[1] += (k & 2) ? -HALF_TURN : HALF_TURN;
                trial[2] += (k & 1) ? -HALF_TURN : HALF_TURN;
            end
            if (c >= FIRST_FLIP)
                trial[1] = -trial[1];
            s = 0;
            for (int j = 0; j < NUM_AXES; j++)
            begin
                d[j] = excess(trial[j], bounds_reg[CFG_BOUNDS_ROLL + j]);
                s += squared(d[j]);
            end
            if (c == 0 || s < best_s)
            begin
                best_s = s;
                best_idx = c;
                best = d;
            end
        end
        // six-term sum, saturating at all ones
        acc = '0;
        for (int j = 0; j < NUM_AXES; j++)
        begin
            acc = acc + squared(pos_d[j]);
            if (acc[64])
                acc = {1'b0, {64{1'b1}}};
            acc = acc + squared(best[j]);
            if (acc[64])
                acc = {1'b0, {64{1'b1}}};
        end
        r.disp_x = pos_d[0][31:0];
        r.disp_y = pos_d[1][31:0];
        r.disp_z = pos_d[2][31:0];
        r.disp_roll = best[0][31:0];
        r.disp_pitch = best[1][31:0];
        r.disp_yaw = best[2][31:0];
        r.chosen_offset = CAND_W'(best_idx);
        r.in_constraint = (acc[63:0] < near_limit);
        return r;
    endfunction

    function automatic int report_field(input string name, input longint want,
                                        input longint got);
        if (want != got)
        begin
            $error("%s expected %0d got %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // register shadow, expected item queue and comparison
    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            foreach (bounds_reg[i])
                bounds_reg[i] = '0;
            near_limit = THRESH_RESET;
            expected_results.delete();
            fail_count = 0;
            errors <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_NEAR_THRESH)
                    near_limit = cfg_data;
                else if (cfg_index < NUM_BOUNDS)
                    bounds_reg[cfg_index] = cfg_data;
            end
            if (done)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result item with no pose pending");
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    fail_count += report_field("disp_x", want.disp_x, result.disp_x);
                    fail_count += report_field("disp_y", want.disp_y, result.disp_y);
                    fail_count += report_field("disp_z", want.disp_z, result.disp_z);
                    fail_count += report_field("disp_roll", want.disp_roll,
                                               result.disp_roll);
                    fail_count += report_field("disp_pitch", want.disp_pitch,
                                               result.disp_pitch);
                    fail_count += report_field("disp_yaw", want.disp_yaw,
                                               result.disp_yaw);
                    fail_count += report_field("chosen_offset", want.chosen_offset,
                                               result.chosen_offset);
                    fail_count += report_field("in_constraint", want.in_constraint,
                                               result.in_constraint);
                end
            end
            if (start && !busy)
                expected_results.push_back(predict_displacement(pose));
            outstanding <= expected_results.size();
            errors <= fail_count;
        end
    end

endmodule

// ===== tb/tb_pose_region_box_displacement.sv =====
module tb_pose_region_box_displacement;
    import prbd_pkg::*;

    localparam int   CYCLE_LIMIT   = 200000;
    localparam int   RANDOM_PHASES = 8;
    localparam int   PHASE_ITEMS   = 181;
    localparam int   DRAIN_CYCLES  = 12;
    localparam fix_t FIX_MAX       = 32'sh7FFF_FFFF;
    localparam fix_t FIX_MIN       = 32'sh8000_0000;
    localparam fix_t ONE           = 32'sh0001_0000;
    localparam fix_t PI_FIX        = fix_t'(PI_Q);
    localparam fix_t HALF_PI       = fix_t'(PI_Q >>> 1);
    localparam fix_t QUARTER_PI    = fix_t'(PI_Q >>> 2);

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    pose_t                pose = '0;
    logic                 done;
    result_t              result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    int                   errors;
    int                   outstanding;
    int                   idle_mode = 1;
    logic [CFG_W-1:0]     cfg_shadow [NUM_BOUNDS+1];

    pose_region_box_displacement DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .pose      (pose),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    displacement_checker check (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .pose        (pose),
        .done        (done),
        .result      (result),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    // offer one pose after a random gap and wait until it is taken
    task automatic send_pose(input pose_t p);
        int gap;
        case (idle_mode)
            0: gap = 0;
            1: gap = $urandom_range(0, 17);
            default: gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        endcase
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        pose <= p;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    // stop offering and wait for every pending result
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // write all registers back to back
    task automatic write_config(input logic [CFG_W-1:0] vals [NUM_BOUNDS+1]);
        for (int i = 0; i <= NUM_BOUNDS; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= cfg_idx_t'(i);
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            cfg_shadow[i] = vals[i];
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [CFG_W-1:0] pick_bounds();
        longint lo;
        longint hi;
        case ($urandom_range(0, 9))
            0: return {$urandom, $urandom};
            1: return '0;
            2: return {FIX_MAX, FIX_MIN};
            3: return $urandom_range(0, 1) ? {FIX_MAX, FIX_MAX} : {FIX_MIN, FIX_MIN};
            default:
            begin
                lo = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
                hi = lo + longint'($urandom_range(0, 1 << 19));
                return {hi[31:0], lo[31:0]};
            end
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_limit();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return THRESH_RESET;
            3: return {$urandom, $urandom};
            default: return 64'd1 << $urandom_range(0, 63);
        endcase
    endfunction

    // one field value, mostly near or inside the current interval
    function automatic fix_t pick_value(input logic [CFG_W-1:0] b, input bit is_angle);
        longint          lo;
        longint          hi;
        longint          v;
        longint          turns;
        longint unsigned span;
        lo = longint'($signed(b[31:0]));
        hi = longint'($signed(b[63:32]));
        case ($urandom_range(0, 9))
            0: v = longint'($signed($urandom));
            1:
            begin
                case ($urandom_range(0, 3))
                    0: v = FIX_MIN;
                    1: v = FIX_MAX;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
            2, 3, 4, 5:
            begin
                if (lo <= hi)
                begin
                    span = hi - lo + 1;
                    v = lo + longint'({$urandom, $urandom} % span);
                end
                else
                    v = longint'($signed($urandom));
            end
            6, 7: v = ($urandom_range(0, 1) ? lo : hi) + longint'($urandom_range(0, 512)) - 256;
            default:
            begin
                if (is_angle)
                begin
                    // land a whole number of half turns away from an edge
                    turns = longint'($urandom_range(1, 2));
                    if ($urandom_range(0, 1))
                        turns = -turns;
                    v = ($urandom_range(0, 1) ? lo : hi) + turns * longint'(PI_Q)
                        + longint'($urandom_range(0, 64)) - 32;
                end
                else
                    v = longint'($urandom_range(0, 1 << 19)) - (1 << 18);
            end
        endcase
        return v[31:0];
    endfunction

    initial
    begin
        logic [CFG_W-1:0] regs [NUM_BOUNDS+1];
        pose_t            p;
        foreach (cfg_shadow[i])
            cfg_shadow[i] = '0;
        cfg_shadow[CFG_NEAR_THRESH] = THRESH_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset bounds: zero-width intervals, threshold near 65 squared
        idle_mode = 1;
        send_pose('{fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0)});
        send_pose('{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX});
        send_pose('{FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN});
        send_pose('{fix_t'(0), fix_t'(0), fix_t'(0), PI_FIX, fix_t'(0), -PI_FIX});
        send_pose('{fix_t'(65), fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0)});
        send_pose('{fix_t'(66), fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0)});
        send_pose('{fix_t'(1), fix_t'(-1), fix_t'(1), fix_t'(-1), fix_t'(1), fix_t'(0)});

        // plain, inverted and pinned intervals, threshold all ones
        drain();
        regs = '{{ONE, -ONE}, {-ONE, ONE}, {FIX_MAX, FIX_MAX}, {HALF_PI, -HALF_PI},
                 {QUARTER_PI, -QUARTER_PI}, 64'd0, '1};
        write_config(regs);
        send_pose('{ONE >>> 1, fix_t'(0), FIX_MAX, fix_t'(0), fix_t'(0), fix_t'(0)});
        send_pose('{-(ONE <<< 1), ONE <<< 1, FIX_MIN, PI_FIX, fix_t'(32'h1000), -PI_FIX});
        send_pose('{ONE <<< 1, -(ONE <<< 1), fix_t'(0), -PI_FIX, PI_FIX, PI_FIX});
        send_pose('{ONE, ONE, FIX_MAX - 1, fix_t'(0), -QUARTER_PI, QUARTER_PI});
        send_pose('{-ONE, fix_t'(32'h8000), fix_t'(0), HALF_PI + 1, fix_t'(32'h0002_E666),
                    fix_t'(32'hFFFD_0000)});
        send_pose('{FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN});
        send_pose('{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX});

        // everything pinned at the top: negative saturation and sum overflow
        drain();
        regs = '{{FIX_MAX, FIX_MAX}, {FIX_MAX, FIX_MAX}, {FIX_MAX, FIX_MAX},
                 {FIX_MAX, FIX_MAX}, {FIX_MAX, FIX_MAX}, {FIX_MAX, FIX_MAX}, '1};
        write_config(regs);
        send_pose('{FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN});
        send_pose('{fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0), fix_t'(0)});
        send_pose('{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX});

        // pinned at the bottom: positive saturation, zero threshold
        drain();
        regs = '{{FIX_MIN, FIX_MIN}, {FIX_MIN, FIX_MIN}, {FIX_MIN, FIX_MIN},
                 {FIX_MIN, FIX_MIN}, {FIX_MIN, FIX_MIN}, {FIX_MIN, FIX_MIN}, 64'd0};
        write_config(regs);
        send_pose('{FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX});
        send_pose('{FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN});

        // random phases, each with its own bounds and idle pattern
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            foreach (regs[i])
                regs[i] = (i == CFG_NEAR_THRESH) ? pick_limit() : pick_bounds();
            if (ph == 0)
            begin
                foreach (regs[i])
                    regs[i] = {FIX_MAX, FIX_MIN};
                regs[CFG_NEAR_THRESH] = 64'd1;
            end
            write_config(regs);
            idle_mode = $urandom_range(0, 2);
            repeat (PHASE_ITEMS)
            begin
                p.pos_x = pick_value(cfg_shadow[CFG_BOUNDS_X], 1'b0);
                p.pos_y = pick_value(cfg_shadow[CFG_BOUNDS_Y], 1'b0);
                p.pos_z = pick_value(cfg_shadow[CFG_BOUNDS_Z], 1'b0);
                p.angle_roll = pick_value(cfg_shadow[CFG_BOUNDS_ROLL], 1'b1);
                p.angle_pitch = pick_value(cfg_shadow[CFG_BOUNDS_PITCH], 1'b1);
                p.angle_yaw = pick_value(cfg_shadow[CFG_BOUNDS_YAW], 1'b1);
                send_pose(p);
            end
        end

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
